/* rtl/assert_macros.svh */
// Assertion macros shared by the tape reader link loader RTL.
// No dependencies; NO_ASSERTIONS removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TLR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("tlr assertion failed");
`define TLR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tlr assertion failed");
`else
`define TLR_ASSERT(lbl, clk, rstn, prop)
`define TLR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/tlr_pkg.sv */
// Types, codes and constants of the tape reader link loader.
// No dependencies; used by every module of the block.
package tlr_pkg;

    // tape depth is a power of two; the pointer is taken modulo the depth
    localparam int TAPE_DEPTH = 65536;
    localparam int TAPE_AW    = $clog2(TAPE_DEPTH);
    typedef logic [TAPE_AW-1:0] t_addr;

    localparam int QDEPTH = 4;
    localparam int Q_AW   = $clog2(QDEPTH);
    localparam int Q_CW   = Q_AW + 1;

    typedef enum logic [2:0] {
        OP_LINK  = 3'd0,
        OP_RSEL  = 3'd1,
        OP_PSEL  = 3'd2,
        OP_ACT   = 3'd3,
        OP_PUNCH = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_SKIP2 = 3'd1,
        MODE_LEN   = 3'd2,
        MODE_DATA  = 3'd3,
        MODE_SKIP1 = 3'd4
    } t_mode;

    localparam logic [7:0] CMD_LOAD_HDR = 8'h80;
    localparam logic [7:0] CMD_BLOCK    = 8'h81;
    localparam logic [7:0] CMD_REWIND   = 8'h82;
    localparam logic [7:0] CMD_ECHO_ON  = 8'h84;
    localparam logic [7:0] CMD_ECHO_OFF = 8'h85;
    localparam logic [7:0] CMD_ONLINE_A = 8'h88;
    localparam logic [7:0] CMD_ONLINE_B = 8'h89;
    localparam logic [7:0] CMD_FLAG     = 8'h8A;

    localparam logic [7:0] ACK_BYTE = 8'h81;
    localparam logic [7:0] ECHO_BIT = 8'h20;

    localparam logic [1:0] KIND_LINK  = 2'd0;
    localparam logic [1:0] KIND_READY = 2'd1;
    localparam logic [1:0] KIND_LINES = 2'd2;

    // slot 0: data lines, slot 1: READY low, slot 2: echo, slot 3: generic result
    typedef struct packed {
        logic [3:0] en;
        logic [4:0] code;
        logic [1:0] s3_kind;
        logic [7:0] s3_value;
    } t_cmd;

    function automatic t_addr ptr_addr(input logic [15:0] p);
        return t_addr'(p);
    endfunction

endpackage

/* rtl/tlr_front.sv */
// Front end: link parser, line state, tape memory and clearing pass.
// Depends on tlr_pkg; feeds result commands to tlr_queue.
module tlr_front import tlr_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [2:0]      i_opcode,
    input  logic [7:0]      i_value,
    input  logic [Q_CW-1:0] i_q_count,
    output logic            o_full,
    output logic            o_q_push,
    output t_cmd            o_q_data
);

    t_mode       r_mode, n_mode;
    logic [8:0]  r_left, n_left;
    logic [15:0] r_load_ptr, n_load_ptr;
    logic [15:0] r_read_ptr, n_read_ptr;
    logic        r_echo, n_echo;
    logic        r_rsel, n_rsel;
    logic        r_psel, n_psel;
    logic [4:0]  r_punch, n_punch;
    logic        r_clearing;
    t_addr       r_clr_addr;
    logic        r_s1_valid;
    t_cmd        r_s1_cmd;
    logic [4:0]  r_rdata;
    logic [4:0]  r_tape [TAPE_DEPTH];

    logic        accept;
    logic        level;
    logic        data_we;
    logic        mem_we;
    t_addr       mem_waddr;
    logic [4:0]  mem_wdata;
    logic        cmd_valid;
    t_cmd        cmd;
    logic [Q_CW:0] used;

    assign used   = {1'b0, i_q_count} + {{Q_CW{1'b0}}, r_s1_valid};
    assign o_full = r_clearing || (used >= (Q_CW+1)'(QDEPTH));
    assign accept = i_push && !o_full;
    assign level  = i_value[0];

    always_comb begin
        n_mode     = r_mode;
        n_left     = r_left;
        n_load_ptr = r_load_ptr;
        n_read_ptr = r_read_ptr;
        n_echo     = r_echo;
        n_rsel     = r_rsel;
        n_psel     = r_psel;
        n_punch    = r_punch;
        data_we    = 1'b0;
        cmd_valid  = 1'b0;
        cmd        = '0;
        if (accept) begin
            case (t_op'(i_opcode))
                OP_LINK: begin
                    unique case (r_mode)
                        MODE_SKIP2: begin
                            n_left = r_left - 9'd1;
                            if (n_left == 9'd0) begin
                                cmd_valid  = 1'b1;
                                cmd.en     = 4'b1000;
                                cmd.s3_kind  = KIND_LINK;
                                cmd.s3_value = ACK_BYTE;
                                n_load_ptr = '0;
                                n_read_ptr = '0;
                                n_mode     = MODE_IDLE;
                            end
                        end
                        MODE_LEN: begin
                            n_left = (i_value == 8'd0) ? 9'd256 : {1'b0, i_value};
                            n_mode = MODE_DATA;
                        end
                        MODE_DATA: begin
                            data_we    = 1'b1;
                            n_load_ptr = r_load_ptr + 16'd1;
                            n_left     = r_left - 9'd1;
                            if (n_left == 9'd0) begin
                                cmd_valid    = 1'b1;
                                cmd.en       = 4'b1000;
                                cmd.s3_kind  = KIND_LINK;
                                cmd.s3_value = ACK_BYTE;
                                n_mode       = MODE_IDLE;
                            end
                        end
                        MODE_SKIP1: n_mode = MODE_IDLE;
                        default: begin
                            n_mode = MODE_IDLE;
                            unique case (i_value)
                                CMD_LOAD_HDR: begin
                                    n_mode = MODE_SKIP2;
                                    n_left = 9'd2;
                                end
                                CMD_BLOCK:    n_mode = MODE_LEN;
                                CMD_REWIND:   n_read_ptr = '0;
                                CMD_ECHO_ON:  n_echo = 1'b1;
                                CMD_ECHO_OFF: n_echo = 1'b0;
                                CMD_ONLINE_A, CMD_ONLINE_B: begin
                                end
                                CMD_FLAG:     n_mode = MODE_SKIP1;
                                default: begin
                                end
                            endcase
                        end
                    endcase
                end
                OP_RSEL, OP_PSEL: begin
                    if (t_op'(i_opcode) == OP_RSEL) begin
                        n_rsel = level;
                    end else begin
                        n_psel = level;
                    end
                    if (level) begin
                        cmd_valid    = 1'b1;
                        cmd.en       = 4'b1000;
                        cmd.s3_kind  = KIND_READY;
                        cmd.s3_value = 8'd1;
                    end
                end
                OP_ACT: begin
                    if (level) begin
                        if (r_rsel) begin
                            n_read_ptr = r_read_ptr + 16'd1;
                        end
                        cmd_valid    = r_rsel || r_psel;
                        cmd.en       = {r_psel, r_rsel && r_echo, r_rsel, r_rsel};
                        cmd.s3_kind  = KIND_LINK;
                        cmd.s3_value = {3'd0, r_punch};
                    end else if (r_rsel) begin
                        cmd_valid    = 1'b1;
                        cmd.en       = 4'b1000;
                        cmd.s3_kind  = KIND_LINES;
                        cmd.s3_value = 8'd0;
                    end
                end
                OP_PUNCH: n_punch = i_value[4:0];
                default: begin
                end
            endcase
        end
    end

    assign mem_we    = r_clearing || data_we;
    assign mem_waddr = r_clearing ? r_clr_addr : ptr_addr(r_load_ptr);
    assign mem_wdata = r_clearing ? 5'd0 : i_value[4:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
        end else begin
            r_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= '0;
            r_load_ptr <= '0;
            r_read_ptr <= '0;
            r_echo     <= 1'b0;
            r_rsel     <= 1'b0;
            r_psel     <= 1'b0;
            r_punch    <= '0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_left     <= n_left;
            r_load_ptr <= n_load_ptr;
            r_read_ptr <= n_read_ptr;
            r_echo     <= n_echo;
            r_rsel     <= n_rsel;
            r_psel     <= n_psel;
            r_punch    <= n_punch;
            r_s1_valid <= cmd_valid;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + t_addr'(1);
                if (r_clr_addr == t_addr'(TAPE_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_cmd <= cmd;
    end

    // tape memory: one write port, one registered read at the read pointer
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tape[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_tape[ptr_addr(r_read_ptr)];
    end

    always_comb begin
        o_q_data      = r_s1_cmd;
        o_q_data.code = r_rdata;
    end
    assign o_q_push = r_s1_valid;

endmodule

/* rtl/tlr_queue.sv */
// Short command queue between the front end and the result sequencer.
// Depends on tlr_pkg.
module tlr_queue import tlr_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  t_cmd            i_data,
    input  logic            i_pop,
    output t_cmd            o_head,
    output logic            o_empty,
    output logic [Q_CW-1:0] o_count
);

    t_cmd            r_mem [QDEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            r_count <= r_count + Q_CW'(i_push) - Q_CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

/* rtl/tlr_back.sv */
// Result sequencer: expands one queued command into its results, one per cycle
// while the output register is free. Depends on tlr_pkg, assert_macros.svh.
`include "assert_macros.svh"
module tlr_back import tlr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  logic       i_q_empty,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [1:0] o_kind,
    output logic [7:0] o_value_res,
    output logic       o_last
);

    logic [3:0] r_taken;
    logic       r_out_valid;
    logic [1:0] r_kind;
    logic [7:0] r_value;
    logic       r_last;

    logic [3:0] remaining;
    logic [3:0] cur;
    logic       last;
    logic       emit;
    logic [1:0] kind;
    logic [7:0] value;

    assign remaining = i_head.en & ~r_taken;
    assign cur       = remaining & (~remaining + 4'd1);
    assign last      = (remaining & ~cur) == 4'd0;
    assign emit      = !i_q_empty && (!r_out_valid || i_pop);
    assign o_q_pop   = emit && last;

    always_comb begin
        case (cur)
            4'b0001: begin
                kind  = KIND_LINES;
                value = {3'd0, i_head.code};
            end
            4'b0010: begin
                kind  = KIND_READY;
                value = 8'd0;
            end
            4'b0100: begin
                kind  = KIND_LINK;
                value = {3'd0, i_head.code} | ECHO_BIT;
            end
            default: begin
                kind  = i_head.s3_kind;
                value = i_head.s3_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_taken     <= last ? 4'd0 : (r_taken | cur);
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind  <= kind;
            r_value <= value;
            r_last  <= last;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_kind      = r_kind;
    assign o_value_res = r_value;
    assign o_last      = r_last;

    `TLR_ASSERT_IMP(a_taken_clear, i_clk, i_rst_n, i_q_empty, r_taken == 4'd0)
    `TLR_ASSERT_IMP(a_cmd_nonempty, i_clk, i_rst_n, !i_q_empty, remaining != 4'd0)
    `TLR_ASSERT_IMP(a_one_slot, i_clk, i_rst_n, emit, $onehot(cur))

endmodule

/* rtl/tape_reader_link_loader.sv */
// Top level of the tape reader link loader: front end, command queue, sequencer.
// Depends on tlr_pkg, tlr_front, tlr_queue, tlr_back.
//
//   channel   handshake          payload
//   input     push / full        i_opcode[2:0], i_value[7:0]
//   result    empty / pop        o_kind[1:0], o_value_res[7:0], o_last
//
// One input item per cycle while the command queue has room (full tracks
// the queue fill plus the one command in flight from the tape read).
// The sequencer sends one result per cycle while pop keeps up, up to four per
// item, via the front-end command register, the queue and the output register.
// The tape memory is cleared after reset, one entry a cycle over TAPE_DEPTH
// (65536) entries with full high. Stalled results back up into the queue.
module tape_reader_link_loader import tlr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_value,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_kind,
    output logic [7:0] o_value_res,
    output logic       o_last
);

    logic            q_push;
    t_cmd            q_data;
    logic            q_pop;
    t_cmd            q_head;
    logic            q_empty;
    logic [Q_CW-1:0] q_count;

    tlr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_opcode  (i_opcode),
        .i_value   (i_value),
        .i_q_count (q_count),
        .o_full    (full),
        .o_q_push  (q_push),
        .o_q_data  (q_data)
    );

    tlr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_data),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    tlr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_kind      (o_kind),
        .o_value_res (o_value_res),
        .o_last      (o_last)
    );

endmodule
